FILE: hw/rtl/pnlq_pkg.sv
// Package for the periodic neighbor list query block.
// Holds item, result, command and geometry types plus op, status and register codes.
`default_nettype none

package pnlq_pkg;

	localparam int TAG_W    = 10;
	localparam int POS_W    = 32;
	localparam int BOX_W    = 31;
	localparam int RAD_W    = 30;
	localparam int CNT_IN_W = 11;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_EXCL  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TAG_RANGE   = 3'd1;
	localparam logic [2:0] ST_FIRST_FULL  = 3'd2;
	localparam logic [2:0] ST_SECOND_FULL = 3'd3;
	localparam logic [2:0] ST_BOX_SMALL   = 3'd4;

	localparam logic [2:0] CFG_BOX_X  = 3'd0;
	localparam logic [2:0] CFG_BOX_Y  = 3'd1;
	localparam logic [2:0] CFG_BOX_Z  = 3'd2;
	localparam logic [2:0] CFG_CUT    = 3'd3;
	localparam logic [2:0] CFG_BUFFER = 3'd4;
	localparam logic [2:0] CFG_FULL   = 3'd5;
	localparam logic [2:0] CFG_COUNT  = 3'd6;

	typedef struct packed {
		logic [1:0]              op;
		logic [TAG_W-1:0]        slot;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [TAG_W-1:0]        tag_a;
		logic [TAG_W-1:0]        tag_b;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] neighbor_slot;
		logic             has_neighbor;
		logic             last;
		logic             overflow;
		logic [2:0]       status;
	} out_item_t;

	typedef struct packed {
		in_item_t item;
		logic     load_ok;
		logic     pair_ok;
		logic     query_ok;
	} cmd_t;

	typedef struct packed {
		logic [BOX_W-1:0]   box_x;
		logic [BOX_W-1:0]   box_y;
		logic [BOX_W-1:0]   box_z;
		logic [BOX_W-1:0]   rmax;
		logic [2*BOX_W-1:0] rsq;
		logic               box_bad;
		logic               full_mode;
	} geom_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic [TAG_W-1:0] tag;
	} particle_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
	} excl_ent_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pnlq_front.sv
// Front end: accepts items, classifies them against the current particle count (loads against MAX_PARTICLES).
// Short command queue toward the back end. Depends on pnlq_pkg.
`default_nettype none

module pnlq_front import pnlq_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int CW            = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire in_item_t      cmd,
	input  wire logic [CW-1:0] active_n,
	input  wire logic          hold,
	input  wire logic          deq,
	output logic               avail,
	output cmd_t               head
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	cmd_t          q_mem [DEPTH];
	cmd_t          cls;
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic [CW-1:0] slot_w, ta_w, tb_w;
	logic          wr, rd;

	assign slot_w = CW'(cmd.slot);
	assign ta_w   = CW'(cmd.tag_a);
	assign tb_w   = CW'(cmd.tag_b);

	always_comb begin
		cls.item     = cmd;
		cls.load_ok  = slot_w < CW'(MAX_PARTICLES);
		cls.pair_ok  = (ta_w < active_n) && (tb_w < active_n);
		cls.query_ok = slot_w < active_n;
	end

	assign full  = hold || (cnt_q == (PW+1)'(DEPTH));
	assign avail = cnt_q != '0;
	assign wr    = push && !full;
	assign rd    = deq && avail;
	assign head  = q_mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) q_mem[wp_q] <= cls;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pnlq_back.sv
// Back end: particle and exclusion memories, command sequencer, query walk pipeline
// and result queue. Depends on pnlq_pkg.
`default_nettype none

module pnlq_back import pnlq_pkg::*; #(
	parameter int MAX_PARTICLES   = 1024,
	parameter int MAX_NEIGHBORS   = 64,
	parameter int EXCLUSION_SLOTS = 4,
	parameter int AW              = 10,
	parameter int CW              = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire geom_t         geom,
	input  wire logic [CW-1:0] active_n,
	input  wire logic          avail,
	input  wire cmd_t          head,
	output logic               deq,
	output logic               clearing,
	input  wire logic          pop,
	output logic               empty,
	output out_item_t          rsp
);

	typedef excl_ent_t [EXCLUSION_SLOTS-1:0] xrow_t;

	localparam int NW  = $clog2(MAX_NEIGHBORS + 1);
	localparam int RD  = 4;
	localparam int RPW = $clog2(RD);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RESP   = 4'd2;
	localparam logic [3:0] S_EXA_RD = 4'd3;
	localparam logic [3:0] S_EXA    = 4'd4;
	localparam logic [3:0] S_EXB_RD = 4'd5;
	localparam logic [3:0] S_EXB    = 4'd6;
	localparam logic [3:0] S_Q_RD   = 4'd7;
	localparam logic [3:0] S_Q_LAT  = 4'd8;
	localparam logic [3:0] S_WALK   = 4'd9;
	localparam logic [3:0] S_DRAIN  = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	function automatic logic [33:0] wrap_d(input logic [32:0] d, input logic [30:0] len);
		logic signed [33:0] ds, ls, d2;
		ds = $signed({d[32], d});
		ls = $signed({3'b000, len});
		d2 = ds <<< 1;
		if (d2 >= ls) return ds - ls;
		else if (d2 < -ls) return ds + ls;
		else return ds;
	endfunction

	// memories
	particle_t     pmem [MAX_PARTICLES];
	xrow_t         xmem [MAX_PARTICLES];
	particle_t     prd_q, p_wd;
	xrow_t         xrd_q, x_wd, new_row;
	logic          p_we, x_we, rd_en, fnd;
	logic [AW-1:0] p_ra, p_wa, x_ra, x_wa;
	logic [TAG_W-1:0] ins_tag;

	// control
	logic [3:0]    state_q;
	logic [2:0]    rsp_st_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] j_q, slot_w;
	logic [NW-1:0] cnt_q;
	logic          pend_q, ovf_q;
	logic [AW-1:0] pend_slot_q;
	cmd_t          cur_q;
	particle_t     pi_q;

	// walk pipeline
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [AW-1:0] j_s1, j_s2, j_s3, j_s4, j_s5, j_s6;
	logic          ltj_s1;
	logic [32:0]   dx_s2, dy_s2, dz_s2;
	logic [TAG_W-1:0] oth_s2, own_tag;
	logic          own_ok_s2;
	logic [33:0]   wx_s3, wy_s3, wz_s3;
	logic          excl_s3, excl_s4, excl_s5, excl_s6;
	logic [33:0]   ax_s4, ay_s4, az_s4;
	logic [61:0]   sqx_s5, sqy_s5, sqz_s5;
	logic          near_s5, near_s6;
	logic [63:0]   sum_s6;
	logic          xmatch;

	logic walking, en, issue, keep, hit, take, cap, pipe_busy;

	// result queue
	out_item_t      rmem [RD];
	out_item_t      r_data;
	logic [RPW-1:0] rwp_q, rrp_q;
	logic [RPW:0]   rcnt_q;
	logic           r_push, r_pop, rfull;

	assign slot_w    = CW'(cur_q.item.slot);
	assign rfull     = rcnt_q == (RPW+1)'(RD);
	assign empty     = rcnt_q == '0;
	assign r_pop     = pop && !empty;
	assign rsp       = rmem[rrp_q];
	assign clearing  = state_q == S_CLEAR;
	assign deq       = (state_q == S_IDLE) && avail;
	assign walking   = (state_q == S_WALK) || (state_q == S_DRAIN);
	assign en        = !rfull;
	assign issue     = (state_q == S_WALK) && (j_q < active_n);
	assign keep      = (j_q != slot_w) && (geom.full_mode || (j_q > slot_w));
	assign hit       = v_s6 && near_s6 && !excl_s6 && (sum_s6 < 64'(geom.rsq));
	assign take      = walking && en && hit && !ovf_q;
	assign cap       = cnt_q == NW'(MAX_NEIGHBORS);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6;
	assign own_tag   = ltj_s1 ? prd_q.tag : pi_q.tag;

	// particle memory
	assign rd_en = walking ? en : 1'b1;
	assign p_ra  = walking ? j_q[AW-1:0] : AW'(cur_q.item.slot);
	assign p_we  = deq && (head.item.op == OP_LOAD) && head.load_ok;
	assign p_wa  = AW'(head.item.slot);
	always_comb begin
		p_wd.pos_x = head.item.pos_x;
		p_wd.pos_y = head.item.pos_y;
		p_wd.pos_z = head.item.pos_z;
		p_wd.tag   = head.item.tag_a;
	end

	always_ff @(posedge clk) begin
		if (p_we) pmem[p_wa] <= p_wd;
		if (rd_en) prd_q <= pmem[p_ra];
	end

	// exclusion memory
	assign ins_tag = (state_q == S_EXA) ? cur_q.item.tag_b : cur_q.item.tag_a;

	always_comb begin
		fnd     = 1'b0;
		new_row = xrd_q;
		for (int k = 0; k < EXCLUSION_SLOTS; k++) begin
			if (!fnd && !xrd_q[k].valid) begin
				fnd            = 1'b1;
				new_row[k].valid = 1'b1;
				new_row[k].tag   = ins_tag;
			end
		end
	end

	always_comb begin
		x_we = 1'b0;
		x_wa = clr_q;
		x_wd = '0;
		if (state_q == S_CLEAR) begin
			x_we = 1'b1;
		end else if ((state_q == S_EXA) && fnd) begin
			x_we = 1'b1;
			x_wa = AW'(cur_q.item.tag_a);
			x_wd = new_row;
		end else if ((state_q == S_EXB) && fnd) begin
			x_we = 1'b1;
			x_wa = AW'(cur_q.item.tag_b);
			x_wd = new_row;
		end
	end

	always_comb begin
		if (walking) x_ra = AW'(own_tag);
		else if (state_q == S_EXB_RD) x_ra = AW'(cur_q.item.tag_b);
		else x_ra = AW'(cur_q.item.tag_a);
	end

	always_ff @(posedge clk) begin
		if (x_we) xmem[x_wa] <= x_wd;
		if (rd_en) xrd_q <= xmem[x_ra];
	end

	always_comb begin
		xmatch = 1'b0;
		for (int k = 0; k < EXCLUSION_SLOTS; k++) begin
			if (xrd_q[k].valid && (xrd_q[k].tag == oth_s2)) xmatch = 1'b1;
		end
	end

	// result push
	always_comb begin
		r_push = 1'b0;
		r_data = '0;
		r_data.last = 1'b1;
		if ((state_q == S_RESP) && !rfull) begin
			r_push        = 1'b1;
			r_data.status = rsp_st_q;
		end else if (take && !cap && pend_q) begin
			r_push               = 1'b1;
			r_data.neighbor_slot = TAG_W'(pend_slot_q);
			r_data.has_neighbor  = 1'b1;
			r_data.last          = 1'b0;
		end else if ((state_q == S_DONE) && !rfull) begin
			r_push = 1'b1;
			if (pend_q) begin
				r_data.neighbor_slot = TAG_W'(pend_slot_q);
				r_data.has_neighbor  = 1'b1;
				r_data.overflow      = ovf_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q  <= '0;
			rrp_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (r_push) rwp_q <= rwp_q + 1'b1;
			if (r_pop) rrp_q <= rrp_q + 1'b1;
			rcnt_q <= rcnt_q + (RPW+1)'(r_push) - (RPW+1)'(r_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (r_push) rmem[rwp_q] <= r_data;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			rsp_st_q <= ST_OK;
			clr_q    <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			ovf_q    <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= issue && keep;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
			if (take) begin
				if (cap) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					pend_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_PARTICLES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (avail) begin
					unique case (head.item.op)
						OP_LOAD: begin
							rsp_st_q <= ST_OK;
							state_q  <= S_RESP;
						end
						OP_EXCL: begin
							if (head.pair_ok) begin
								state_q <= S_EXA_RD;
							end else begin
								rsp_st_q <= ST_TAG_RANGE;
								state_q  <= S_RESP;
							end
						end
						OP_QUERY: begin
							cnt_q  <= '0;
							pend_q <= 1'b0;
							ovf_q  <= 1'b0;
							j_q    <= '0;
							if (geom.box_bad) begin
								rsp_st_q <= ST_BOX_SMALL;
								state_q  <= S_RESP;
							end else if (!head.query_ok) begin
								rsp_st_q <= ST_OK;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_Q_RD;
							end
						end
						OP_NOP: begin
							rsp_st_q <= ST_OK;
							state_q  <= S_RESP;
						end
					endcase
				end
				S_RESP: if (!rfull) state_q <= S_IDLE;
				S_EXA_RD: state_q <= S_EXA;
				S_EXA: begin
					if (fnd) begin
						state_q <= S_EXB_RD;
					end else begin
						rsp_st_q <= ST_FIRST_FULL;
						state_q  <= S_RESP;
					end
				end
				S_EXB_RD: state_q <= S_EXB;
				S_EXB: begin
					rsp_st_q <= fnd ? ST_OK : ST_SECOND_FULL;
					state_q  <= S_RESP;
				end
				S_Q_RD: state_q <= S_Q_LAT;
				S_Q_LAT: state_q <= S_WALK;
				S_WALK: if (en) begin
					if (issue) j_q <= j_q + 1'b1;
					else state_q <= S_DRAIN;
				end
				S_DRAIN: if (en && !pipe_busy) state_q <= S_DONE;
				S_DONE: if (!rfull) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (deq) cur_q <= head;
		if (state_q == S_Q_LAT) pi_q <= prd_q;
		if (take && !cap) pend_slot_q <= j_s6;
		if (en) begin
			j_s1   <= j_q[AW-1:0];
			ltj_s1 <= j_q < slot_w;

			j_s2      <= j_s1;
			dx_s2     <= {prd_q.pos_x[31], prd_q.pos_x} - {pi_q.pos_x[31], pi_q.pos_x};
			dy_s2     <= {prd_q.pos_y[31], prd_q.pos_y} - {pi_q.pos_y[31], pi_q.pos_y};
			dz_s2     <= {prd_q.pos_z[31], prd_q.pos_z} - {pi_q.pos_z[31], pi_q.pos_z};
			oth_s2    <= ltj_s1 ? pi_q.tag : prd_q.tag;
			own_ok_s2 <= CW'(own_tag) < CW'(MAX_PARTICLES);

			j_s3    <= j_s2;
			wx_s3   <= wrap_d(dx_s2, geom.box_x);
			wy_s3   <= wrap_d(dy_s2, geom.box_y);
			wz_s3   <= wrap_d(dz_s2, geom.box_z);
			excl_s3 <= own_ok_s2 && xmatch;

			j_s4    <= j_s3;
			ax_s4   <= wx_s3[33] ? (34'd0 - wx_s3) : wx_s3;
			ay_s4   <= wy_s3[33] ? (34'd0 - wy_s3) : wy_s3;
			az_s4   <= wz_s3[33] ? (34'd0 - wz_s3) : wz_s3;
			excl_s4 <= excl_s3;

			j_s5    <= j_s4;
			sqx_s5  <= ax_s4[30:0] * ax_s4[30:0];
			sqy_s5  <= ay_s4[30:0] * ay_s4[30:0];
			sqz_s5  <= az_s4[30:0] * az_s4[30:0];
			near_s5 <= (ax_s4 < 34'(geom.rmax)) && (ay_s4 < 34'(geom.rmax))
				&& (az_s4 < 34'(geom.rmax));
			excl_s5 <= excl_s4;

			j_s6    <= j_s5;
			sum_s6  <= 64'(sqx_s5) + 64'(sqy_s5) + 64'(sqz_s5);
			near_s6 <= near_s5;
			excl_s6 <= excl_s5;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_neighbor_list_query.sv
// Periodic neighbor list query, top level: configuration registers, front and back ends.
// During a query walk the particle memory read port serves one stored particle a cycle
// while the result queue has room; a full result queue stalls the walk. After reset the
// exclusion table is cleared one row a cycle, with full held high.
`default_nettype none

module periodic_neighbor_list_query import pnlq_pkg::*; #(
	parameter int MAX_PARTICLES   = 1024,
	parameter int MAX_NEIGHBORS   = 64,
	parameter int EXCLUSION_SLOTS = 4,
	parameter int FRAC_BITS       = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    cmd,
	input  wire logic        pop,
	output logic             empty,
	output out_item_t        rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = (AW + 1 > CNT_IN_W) ? AW + 1 : CNT_IN_W;

	logic [BOX_W-1:0]    box_x_q, box_y_q, box_z_q, rmax;
	logic [RAD_W-1:0]    cut_q, buf_q;
	logic                full_q;
	logic [CNT_IN_W-1:0] pc_q;
	logic [2*BOX_W-1:0]  rsq_q;
	logic                box_bad;
	logic [CW-1:0]       active_n;
	geom_t               geom;
	cmd_t                head;
	logic                avail, deq, clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BOX_W'(16 << FRAC_BITS);
			box_y_q <= BOX_W'(16 << FRAC_BITS);
			box_z_q <= BOX_W'(16 << FRAC_BITS);
			cut_q   <= RAD_W'(1 << FRAC_BITS);
			buf_q   <= '0;
			full_q  <= 1'b0;
			pc_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BOX_X:  box_x_q <= cfg_data[BOX_W-1:0];
				CFG_BOX_Y:  box_y_q <= cfg_data[BOX_W-1:0];
				CFG_BOX_Z:  box_z_q <= cfg_data[BOX_W-1:0];
				CFG_CUT:    cut_q   <= cfg_data[RAD_W-1:0];
				CFG_BUFFER: buf_q   <= cfg_data[RAD_W-1:0];
				CFG_FULL:   full_q  <= cfg_data[0];
				CFG_COUNT:  pc_q    <= cfg_data[CNT_IN_W-1:0];
				default: ;
			endcase
		end
	end

	assign rmax    = {1'b0, cut_q} + {1'b0, buf_q};
	assign box_bad = ({1'b0, box_x_q} <= {rmax, 1'b0})
		|| ({1'b0, box_y_q} <= {rmax, 1'b0})
		|| ({1'b0, box_z_q} <= {rmax, 1'b0});

	// squared radius is registered and settles in the cycle after a write
	always_ff @(posedge clk) begin
		rsq_q <= rmax * rmax;
	end

	assign active_n = (CW'(pc_q) > CW'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(pc_q);

	always_comb begin
		geom.box_x     = box_x_q;
		geom.box_y     = box_y_q;
		geom.box_z     = box_z_q;
		geom.rmax      = rmax;
		geom.rsq       = rsq_q;
		geom.box_bad   = box_bad;
		geom.full_mode = full_q;
	end

	pnlq_front #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.active_n(active_n),
		.hold(clearing),
		.deq(deq),
		.avail(avail),
		.head(head)
	);

	pnlq_back #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.MAX_NEIGHBORS(MAX_NEIGHBORS),
		.EXCLUSION_SLOTS(EXCLUSION_SLOTS),
		.AW(AW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.geom(geom),
		.active_n(active_n),
		.avail(avail),
		.head(head),
		.deq(deq),
		.clearing(clearing),
		.pop(pop),
		.empty(empty),
		.rsp(rsp)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("item accepted during exclusion clear");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !rsp.has_neighbor) |-> rsp.last)
		else $error("empty result not marked last");

	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.overflow) |-> (rsp.last && rsp.has_neighbor))
		else $error("overflow outside final neighbor");

	a_err_no_nb: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != ST_OK) |-> !rsp.has_neighbor)
		else $error("error status with neighbor");

endmodule

`default_nettype wire

FILE: verif/periodic_neighbor_list_query_checker.sv
// Checker for the periodic neighbor list query block: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on pnlq_pkg for the item, result, op, status and register codes.
`timescale 1ns / 1ps

module periodic_neighbor_list_query_checker import pnlq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire in_item_t    cmd,
	input  wire logic        pop,
	input  wire logic        empty,
	input  wire out_item_t   rsp,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               pending,
	output int               items_seen,
	output int               results_seen,
	output int               neighbors_seen,
	output int               overflows_seen
);
	localparam int NPART = 1024;
	localparam int NEIGH = 64;
	localparam int XSLOT = 4;

	logic [POS_W-1:0]    px [NPART];
	logic [POS_W-1:0]    py [NPART];
	logic [POS_W-1:0]    pz [NPART];
	logic [TAG_W-1:0]    ptag [NPART];
	logic                xv [NPART][XSLOT];
	logic [TAG_W-1:0]    xt [NPART][XSLOT];

	logic [BOX_W-1:0]    box_x, box_y, box_z;
	logic [RAD_W-1:0]    cut_r, buf_r;
	logic                full_list;
	logic [CNT_IN_W-1:0] part_count;

	out_item_t expected_rsp [$];

	function automatic void add_expected(out_item_t r);
		expected_rsp.insert(expected_rsp.size(), r);
	endfunction

	function automatic longint unsigned axis_gap(logic [31:0] a, logic [31:0] b,
			longint unsigned len);
		longint d;
		longint l;
		d = longint'($signed(b)) - longint'($signed(a));
		l = longint'(len);
		if (2 * d >= l)
			d -= l;
		else if (2 * d < -l)
			d += l;
		return (d < 0) ? longint'(-d) : d;
	endfunction

	function automatic bit tag_excluded(logic [TAG_W-1:0] own, logic [TAG_W-1:0] other);
		for (int k = 0; k < XSLOT; k++)
			if (xv[own][k] && xt[own][k] == other)
				return 1;
		return 0;
	endfunction

	function automatic bit add_exclusion(logic [TAG_W-1:0] owner, logic [TAG_W-1:0] val);
		for (int k = 0; k < XSLOT; k++)
			if (!xv[owner][k]) begin
				xv[owner][k] = 1;
				xt[owner][k] = val;
				return 1;
			end
		return 0;
	endfunction

	function automatic out_item_t plain_rsp(logic [2:0] st);
		out_item_t r;
		r = '0;
		r.last = 1;
		r.status = st;
		return r;
	endfunction

	task automatic predict_results(in_item_t it);
		int unsigned n;
		longint unsigned rmax, ax, ay, az;
		int cnt;
		bit ovf;
		out_item_t r;
		out_item_t found [NEIGH];
		int unsigned lo, hi;
		n = (part_count > NPART) ? NPART : part_count;
		case (it.op)
			OP_LOAD: begin
				px[it.slot] = it.pos_x;
				py[it.slot] = it.pos_y;
				pz[it.slot] = it.pos_z;
				ptag[it.slot] = it.tag_a;
				add_expected(plain_rsp(ST_OK));
			end
			OP_EXCL: begin
				if (it.tag_a >= n || it.tag_b >= n)
					add_expected(plain_rsp(ST_TAG_RANGE));
				else if (!add_exclusion(it.tag_a, it.tag_b))
					add_expected(plain_rsp(ST_FIRST_FULL));
				else if (!add_exclusion(it.tag_b, it.tag_a))
					add_expected(plain_rsp(ST_SECOND_FULL));
				else
					add_expected(plain_rsp(ST_OK));
			end
			OP_QUERY: begin
				rmax = longint'(cut_r) + longint'(buf_r);
				if (box_x <= 2 * rmax || box_y <= 2 * rmax || box_z <= 2 * rmax) begin
					add_expected(plain_rsp(ST_BOX_SMALL));
				end else if (it.slot >= n) begin
					add_expected(plain_rsp(ST_OK));
				end else begin
					cnt = 0;
					ovf = 0;
					for (int unsigned j = 0; j < n; j++) begin
						if (j == it.slot || (!full_list && j < it.slot))
							continue;
						lo = (j < it.slot) ? j : it.slot;
						hi = (j < it.slot) ? it.slot : j;
						if (tag_excluded(ptag[lo], ptag[hi]))
							continue;
						ax = axis_gap(px[it.slot], px[j], box_x);
						ay = axis_gap(py[it.slot], py[j], box_y);
						az = axis_gap(pz[it.slot], pz[j], box_z);
						if (ax >= rmax || ay >= rmax || az >= rmax)
							continue;
						if (ax * ax + ay * ay + az * az >= rmax * rmax)
							continue;
						if (cnt >= NEIGH) begin
							ovf = 1;
							break;
						end
						r = '0;
						r.neighbor_slot = j[TAG_W-1:0];
						r.has_neighbor = 1;
						found[cnt] = r;
						cnt++;
					end
					if (cnt == 0) begin
						add_expected(plain_rsp(ST_OK));
					end else begin
						found[cnt-1].last = 1;
						found[cnt-1].overflow = ovf;
						for (int k = 0; k < cnt; k++)
							add_expected(found[k]);
					end
				end
			end
			default: add_expected(plain_rsp(ST_OK));
		endcase
	endtask

	task automatic reset_state();
		box_x = 31'd1048576;
		box_y = 31'd1048576;
		box_z = 31'd1048576;
		cut_r = 30'd65536;
		buf_r = '0;
		full_list = 0;
		part_count = '0;
		for (int i = 0; i < NPART; i++)
			for (int k = 0; k < XSLOT; k++) begin
				xv[i][k] = 0;
				xt[i][k] = '0;
			end
		expected_rsp.delete();
		pending = 0;
	endtask

	initial begin
		errors = 0;
		items_seen = 0;
		results_seen = 0;
		neighbors_seen = 0;
		overflows_seen = 0;
		reset_state();
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			reset_state();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BOX_X:  box_x = cfg_data[BOX_W-1:0];
					CFG_BOX_Y:  box_y = cfg_data[BOX_W-1:0];
					CFG_BOX_Z:  box_z = cfg_data[BOX_W-1:0];
					CFG_CUT:    cut_r = cfg_data[RAD_W-1:0];
					CFG_BUFFER: buf_r = cfg_data[RAD_W-1:0];
					CFG_FULL:   full_list = cfg_data[0];
					CFG_COUNT:  part_count = cfg_data[CNT_IN_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				results_seen++;
				if (rsp.has_neighbor)
					neighbors_seen++;
				if (rsp.overflow)
					overflows_seen++;
				if (expected_rsp.size() == 0) begin
					$error("unexpected result %p", rsp);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.neighbor_slot !== want.neighbor_slot) begin
						$error("neighbor_slot: expected %0d, got %0d",
							want.neighbor_slot, rsp.neighbor_slot);
						errors++;
					end
					if (rsp.has_neighbor !== want.has_neighbor) begin
						$error("has_neighbor: expected %0d, got %0d",
							want.has_neighbor, rsp.has_neighbor);
						errors++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						errors++;
					end
					if (rsp.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, rsp.overflow);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
				end
			end
			if (push && !full) begin
				items_seen++;
				predict_results(cmd);
			end
			pending = expected_rsp.size();
		end
	end

endmodule

FILE: verif/periodic_neighbor_list_query_tb.sv
// Testbench top for the periodic neighbor list query block: drives items, register
// writes and result pops, and gives the verdict from the checker's error count.
// Depends on pnlq_pkg, the block and periodic_neighbor_list_query_checker.
`timescale 1ns / 1ps

module periodic_neighbor_list_query_tb import pnlq_pkg::*;;
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    cmd;
	logic        pop;
	logic        empty;
	out_item_t   rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int errors, pending, items_seen, results_seen, neighbors_seen, overflows_seen;
	int burst_left;
	int pop_rate;
	int pop_cycles;
	int cur_count;
	int spread;
	int box_min;

	periodic_neighbor_list_query dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.pop(pop), .empty(empty), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	periodic_neighbor_list_query_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.pop(pop), .empty(empty), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .items_seen(items_seen),
		.results_seen(results_seen), .neighbors_seen(neighbors_seen),
		.overflows_seen(overflows_seen)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver stall pattern: the pop rate switches among four levels at random intervals
	initial begin
		pop = 0;
		pop_rate = 100;
		pop_cycles = 0;
	end
	always @(negedge clk) begin
		if (pop_cycles == 0) begin
			case ($urandom_range(0, 3))
				0: pop_rate = 100;
				1: pop_rate = 70;
				2: pop_rate = 40;
				default: pop_rate = 15;
			endcase
			pop_cycles = $urandom_range(50, 300);
		end
		pop_cycles--;
		pop = ($urandom_range(0, 99) < pop_rate);
	end

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send(in_item_t it);
		if (burst_left == 0) begin
			push = 0;
			repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0)
				@(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		cmd = it;
		push = 1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		push = 0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		drain();
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
		if (idx == CFG_COUNT)
			cur_count = (val[10:0] > 1024) ? 1024 : val[10:0];
	endtask

	function automatic in_item_t mk(logic [1:0] op, int unsigned slot, int x, int y, int z,
			int unsigned ta, int unsigned tb);
		in_item_t it;
		it.op = op;
		it.slot = slot[TAG_W-1:0];
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.tag_a = ta[TAG_W-1:0];
		it.tag_b = tb[TAG_W-1:0];
		return it;
	endfunction

	function automatic int coord();
		return int'($urandom_range(0, spread - 1)) - spread / 2;
	endfunction

	function automatic int unsigned some_tag();
		return $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
			: $urandom_range(0, (cur_count > 0 ? cur_count : 1) - 1);
	endfunction

	task automatic load_slot(int unsigned s);
		send(mk(OP_LOAD, s, coord(), coord(), coord(), some_tag(), $urandom()));
	endtask

	task automatic random_phase(int unsigned n, int items, bit dense);
		int unsigned cut;
		box_min = 1 << 30;
		for (int a = 0; a < 3; a++) begin
			int unsigned b;
			b = $urandom_range(1 << 18, 1 << 22);
			if (b < box_min)
				box_min = b;
			write_reg(3'(CFG_BOX_X + a), b);
		end
		cut = box_min / $urandom_range(3, 8);
		write_reg(CFG_CUT, cut);
		write_reg(CFG_BUFFER, $urandom_range(0, cut / 8));
		write_reg(CFG_FULL, $urandom_range(0, 1));
		write_reg(CFG_COUNT, n);
		spread = dense ? cut : box_min;
		for (int unsigned s = 0; s < n; s++)
			load_slot(s);
		for (int k = 0; k < items; k++) begin
			int unsigned pick;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send(mk(OP_QUERY, $urandom_range(0, n - 1), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom()));
			else if (pick < 72)
				send(mk(OP_EXCL, $urandom(), $urandom(), $urandom(), $urandom(),
					some_tag(), some_tag()));
			else if (pick < 85)
				load_slot($urandom_range(0, n - 1));
			else if (pick < 90)
				send(mk(OP_NOP, $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom()));
			else if (pick < 95)
				send(mk(OP_QUERY, $urandom_range(n, 1023), 0, 0, 0, 0, 0));
			else
				send(mk(OP_LOAD, $urandom_range(n, 1023), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom()));
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		cmd = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		cur_count = 0;
		spread = 1 << 20;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// empty particle set: query, out-of-range pair, unused op, load at the top slot
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
		send(mk(OP_EXCL, 0, 0, 0, 0, 0, 0));
		send(mk(OP_NOP, 1023, -1, -1, -1, 1023, 1023));
		send(mk(OP_LOAD, 1023, 32'h7FFFFFFF, 32'h80000000, 0, 1023, 1023));

		// four particles at coordinate extremes, default box and cutoff
		write_reg(CFG_COUNT, 4);
		send(mk(OP_LOAD, 0, 0, 0, 0, 0, 0));
		send(mk(OP_LOAD, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0));
		send(mk(OP_LOAD, 2, 32'h80000000, 32'h80000000, 32'h80000000, 2, 0));
		send(mk(OP_LOAD, 3, 32'h00008000, 32'h000F8000, 0, 3, 0));
		for (int s = 0; s < 4; s++)
			send(mk(OP_QUERY, s, 0, 0, 0, 0, 0));
		send(mk(OP_EXCL, 0, 0, 0, 0, 1, 1));
		send(mk(OP_EXCL, 0, 0, 0, 0, 0, 3));
		send(mk(OP_EXCL, 0, 0, 0, 0, 3, 4));
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
		write_reg(CFG_FULL, 1);
		send(mk(OP_QUERY, 3, 0, 0, 0, 0, 0));

		// box and radius extremes
		write_reg(CFG_BOX_X, 1);
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
		write_reg(CFG_BOX_X, 32'h7FFFFFFF);
		write_reg(CFG_BOX_Y, 32'h7FFFFFFF);
		write_reg(CFG_BOX_Z, 32'h7FFFFFFF);
		write_reg(CFG_CUT, 32'h3FFFFFFF);
		write_reg(CFG_BUFFER, 32'h3FFFFFFF);
		send(mk(OP_QUERY, 1, 0, 0, 0, 0, 0));
		write_reg(CFG_CUT, 0);
		write_reg(CFG_BUFFER, 0);
		send(mk(OP_QUERY, 2, 0, 0, 0, 0, 0));
		write_reg(CFG_CUT, 32'h3FFFFFFF);
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));

		for (int p = 0; p < 6; p++)
			random_phase($urandom_range(2, 40), 40, p[0]);

		// tight cluster: more neighbors than the result limit
		write_reg(CFG_BOX_X, 1 << 22);
		write_reg(CFG_BOX_Y, 1 << 22);
		write_reg(CFG_BOX_Z, 1 << 22);
		write_reg(CFG_CUT, 1 << 16);
		write_reg(CFG_BUFFER, 0);
		write_reg(CFG_FULL, 1);
		write_reg(CFG_COUNT, 80);
		spread = 1 << 14;
		for (int unsigned s = 0; s < 80; s++)
			load_slot(s);
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
		send(mk(OP_QUERY, 79, 0, 0, 0, 0, 0));
		send(mk(OP_QUERY, $urandom_range(0, 79), 0, 0, 0, 0, 0));
		write_reg(CFG_FULL, 0);
		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));

		drain();
		repeat (50) @(negedge clk);
		$display("Ran %0d items through loads, exclusions, queries and unused ops;",
			items_seen);
		$display("checked %0d results, %0d neighbors, %0d overflow flags.",
			results_seen, neighbors_seen, overflows_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/pnlq_pkg.sv
hw/rtl/pnlq_front.sv
hw/rtl/pnlq_back.sv
hw/rtl/periodic_neighbor_list_query.sv
verif/periodic_neighbor_list_query_checker.sv
verif/periodic_neighbor_list_query_tb.sv
